/* rtl/mmbd_pkg.sv */
// ----------------------------------------------------------------------------
// Mipmap box downsampler package
// Shared constants and configuration register indices for the 2x2 box
// filter that builds the next mipmap level.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  // Pixel layout.
  localparam int NUM_COMPS = 4;
  localparam int COMP_W    = 16;
  localparam int PAIR_W    = COMP_W + 1;
  localparam int SUM_W     = COMP_W + 2;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CCOUNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0]    RESET_WIDTH  = 13'd2;
  localparam logic [CFG_W-1:0]    RESET_HEIGHT = 13'd2;
  localparam logic [CCOUNT_W-1:0] RESET_COUNT  = 3'd4;

  // Row geometry: heights are limited to 4096 rows.
  localparam int               ROW_W      = 12;
  localparam logic [CFG_W-1:0] MIN_SIZE   = 13'd2;
  localparam logic [CFG_W-1:0] MAX_HEIGHT = 13'd4096;

endpackage

/* rtl/mmbd_pix_if.sv */
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel carrying one source pixel of four components.
// ----------------------------------------------------------------------------
interface mmbd_pix_if;
  import mmbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] comp_0;
  logic [COMP_W-1:0] comp_1;
  logic [COMP_W-1:0] comp_2;
  logic [COMP_W-1:0] comp_3;

  modport source (output valid, comp_0, comp_1, comp_2, comp_3, input ready);
  modport sink   (input valid, comp_0, comp_1, comp_2, comp_3, output ready);

endinterface

/* rtl/mmbd_res_if.sv */
// ----------------------------------------------------------------------------
// Downsampled pixel channel
// Valid/ready channel carrying one averaged pixel and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface mmbd_res_if;
  import mmbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] avg_0;
  logic [COMP_W-1:0] avg_1;
  logic [COMP_W-1:0] avg_2;
  logic [COMP_W-1:0] avg_3;
  logic              frame_last;

  modport source (output valid, avg_0, avg_1, avg_2, avg_3, frame_last, input ready);
  modport sink   (input valid, avg_0, avg_1, avg_2, avg_3, frame_last, output ready);

endinterface

/* rtl/mipmap_box_downsampler.sv */
// ----------------------------------------------------------------------------
// Mipmap box downsampler
// Builds the next mipmap level by rounding the average of each 2x2 block.
// ----------------------------------------------------------------------------
// Source pixels enter on in_pix in raster order, one transaction per pixel.
// Each completed 2x2 block gives one transaction on out_res, carrying the
// four averages (sum of four plus two, shifted right by two) and frame_last
// on the bottom-right block. An odd last column or row is consumed silently.
// Components at or above component_count read as zero.
// The block takes one pixel per clock while in_pix.ready is high. A result
// passes from the pixel that closes its block through the line store read
// in the read stage, then the adder and the output register. Even rows write
// the horizontal pair sums into the line store; odd rows read them back. The
// line store needs no clearing after reset. When out_res stalls, the output
// register holds the waiting result and one more result may wait in the read
// stage; in_pix.ready drops only when both are occupied. Reset clears the
// counters, the pipeline valid bits and the registers (width 2, height 2,
// four components). The user must write configuration through cfg_we,
// cfg_index and cfg_wdata only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module mipmap_box_downsampler #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  mmbd_pix_if.sink                           in_pix,
  mmbd_res_if.source                         out_res,
  input  logic                               cfg_we,
  input  logic [mmbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmbd_pkg::CFG_W-1:0]         cfg_wdata
);

  import mmbd_pkg::*;

  localparam int XW        = $clog2(MAX_WIDTH + 1);
  localparam int CW        = (XW > CFG_W) ? XW : CFG_W;
  localparam int RAM_DEPTH = MAX_WIDTH / 2;
  localparam int AW        = $clog2(RAM_DEPTH);
  localparam int RAM_W     = NUM_COMPS * PAIR_W;

  // Configuration registers.
  logic [CFG_W-1:0]    src_width_r;
  logic [CFG_W-1:0]    src_height_r;
  logic [CCOUNT_W-1:0] comp_count_r;

  // Position counters and the held left pixel.
  logic [XW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COMP_W-1:0] held_r [NUM_COMPS];

  // Read stage and output register.
  logic              s1_valid_r, s1_valid_nxt;
  logic [PAIR_W-1:0] s1_pair_r [NUM_COMPS];
  logic [NUM_COMPS-1:0] s1_mask_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [COMP_W-1:0] avg_r [NUM_COMPS];
  logic              last_r;

  logic [CW-1:0]     width_cl;
  logic [XW-1:0]     w_c, ew_c, col_inc;
  logic [CFG_W-1:0]  h_c, eh_c, row_inc;
  logic              accept, in_range, col_odd, row_odd;
  logic              ram_we, ram_re, blk_last, s1_move;
  logic [COMP_W-1:0] pix_c  [NUM_COMPS];
  logic [PAIR_W-1:0] pair_c [NUM_COMPS];
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic [NUM_COMPS-1:0] mask_c;
  logic [SUM_W-1:0]  sum_c [NUM_COMPS];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RESET_WIDTH;
      src_height_r <= RESET_HEIGHT;
      comp_count_r <= RESET_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:    src_width_r  <= cfg_wdata;
        CFG_SOURCE_HEIGHT:   src_height_r <= cfg_wdata;
        CFG_COMPONENT_COUNT: comp_count_r <= cfg_wdata[CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame sizes and their even parts.
  always_comb begin
    width_cl = CW'(src_width_r);
    if (src_width_r < MIN_SIZE) begin
      width_cl = CW'(MIN_SIZE);
    end else if (CW'(src_width_r) > CW'(MAX_WIDTH)) begin
      width_cl = CW'(MAX_WIDTH);
    end
    w_c  = XW'(width_cl);
    ew_c = {w_c[XW-1:1], 1'b0};
    h_c  = src_height_r;
    if (src_height_r < MIN_SIZE) begin
      h_c = MIN_SIZE;
    end else if (src_height_r > MAX_HEIGHT) begin
      h_c = MAX_HEIGHT;
    end
    eh_c = {h_c[CFG_W-1:1], 1'b0};
  end

  // Input pixel decode and horizontal pair sums.
  assign pix_c[0] = in_pix.comp_0;
  assign pix_c[1] = in_pix.comp_1;
  assign pix_c[2] = in_pix.comp_2;
  assign pix_c[3] = in_pix.comp_3;

  always_comb begin
    for (int c = 0; c < NUM_COMPS; c++) begin
      pair_c[c] = {1'b0, held_r[c]} + {1'b0, pix_c[c]};
      ram_wdata[c*PAIR_W +: PAIR_W] = pair_c[c];
      mask_c[c] = comp_count_r > CCOUNT_W'(c);
    end
  end

  assign s1_move      = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_pix.ready = !s1_valid_r || s1_move;
  assign accept       = in_pix.valid && in_pix.ready;
  assign in_range     = (col_r < ew_c) && (CFG_W'(row_r) < eh_c);
  assign col_odd      = col_r[0];
  assign row_odd      = row_r[0];
  assign ram_we       = accept && in_range && col_odd && !row_odd;
  assign ram_re       = accept && in_range && col_odd && row_odd;
  assign blk_last     = (col_r == ew_c - XW'(1)) && (CFG_W'(row_r) == eh_c - CFG_W'(1));

  // Raster position: wrap at the end of a row and at the end of the frame.
  always_comb begin
    col_inc = col_r + XW'(1);
    row_inc = CFG_W'(row_r) + CFG_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= w_c) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_c) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The left pixel of each pair is held until its right neighbour arrives.
  always_ff @(posedge clk) begin
    if (accept && in_range && !col_odd) begin
      for (int c = 0; c < NUM_COMPS; c++) begin
        held_r[c] <= pix_c[c];
      end
    end
  end

  // Line store of pair sums, one row of four sums per pixel pair.
  mmbd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RAM_DEPTH)
  ) u_pair_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (col_r[AW:1]),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (col_r[AW:1]),
    .rd_data (ram_rdata)
  );

  // Read stage valid and output valid.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = ram_re;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage payload: this row's pair sums wait for the stored ones.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      for (int c = 0; c < NUM_COMPS; c++) begin
        s1_pair_r[c] <= pair_c[c];
      end
      s1_mask_r <= mask_c;
      s1_last_r <= blk_last;
    end
  end

  // Vertical sum with rounding to nearest.
  always_comb begin
    for (int c = 0; c < NUM_COMPS; c++) begin
      sum_c[c] = SUM_W'(s1_pair_r[c]) + SUM_W'(ram_rdata[c*PAIR_W +: PAIR_W])
                 + SUM_W'(2);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int c = 0; c < NUM_COMPS; c++) begin
        avg_r[c] <= s1_mask_r[c] ? sum_c[c][SUM_W-1:2] : '0;
      end
      last_r <= s1_last_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.avg_0      = avg_r[0];
  assign out_res.avg_1      = avg_r[1];
  assign out_res.avg_2      = avg_r[2];
  assign out_res.avg_3      = avg_r[3];
  assign out_res.frame_last = last_r;

endmodule

/* rtl/mmbd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read.
// ----------------------------------------------------------------------------
module mmbd_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
